### design/scfd_pkg.sv
// Shared constants, types and state codes for the sync checksum frame deframer.
package scfd_pkg;

  // Sync pair and frame layout
  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;
  localparam int unsigned FRAME_LEN  = 36;
  localparam int unsigned SUM_END    = 34;
  localparam int unsigned IDX_W      = 6;

  localparam logic [IDX_W-1:0] IDX_FIRST_DATA = IDX_W'(2);
  localparam logic [IDX_W-1:0] IDX_LAST_FIELD = IDX_W'(26);
  localparam logic [IDX_W-1:0] IDX_SUM_END    = IDX_W'(SUM_END);
  localparam logic [IDX_W-1:0] IDX_CHK_HI     = IDX_W'(SUM_END);
  localparam logic [IDX_W-1:0] IDX_CHK_LO     = IDX_W'(FRAME_LEN - 1);

  // Payload bytes held by the back end: frame bytes 2..26
  localparam int unsigned FIELD_BYTES = 25;
  localparam int unsigned FIELD_IDX_W = 5;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Hunter state
  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_LEAD    = 2'd1,
    PH_COLLECT = 2'd2
  } phase_t;

  // One frame byte tagged with its position in the frame
  typedef struct packed {
    logic [7:0]       data;
    logic [IDX_W-1:0] index;
  } frame_item_t;

  // One decoded frame
  typedef struct packed {
    logic [15:0] timestamp;
    logic [7:0]  pan_speed;
    logic [15:0] pan_vel;
    logic [31:0] pan_pos;
    logic [7:0]  tilt_speed;
    logic [15:0] tilt_vel;
    logic [31:0] tilt_pos;
    logic [7:0]  roll_speed;
    logic [15:0] roll_vel;
    logic [31:0] roll_pos;
    logic [7:0]  direction_bits;
    logic [7:0]  aux_bits;
  } frame_result_t;

endpackage

### design/scfd_front.sv
// Front end: hunts for the sync pair and tags each frame byte with its index.
module scfd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          rx_byte,
  output logic                push,
  output scfd_pkg::frame_item_t push_item,
  input  logic                queue_ready
);
  import scfd_pkg::*;

  phase_t           phase, phase_next;
  logic [IDX_W-1:0] byte_index, byte_index_next;
  logic             accept;

  assign in_ready = queue_ready;
  assign accept   = in_valid && queue_ready;

  // Next state: hunt for 0xAA 0x55, then count out the frame
  always_comb begin
    phase_next      = phase;
    byte_index_next = byte_index;
    if (accept) begin
      unique case (phase)
        PH_COLLECT: begin
          if (byte_index == IDX_CHK_LO) begin
            phase_next      = PH_HUNT;
            byte_index_next = '0;
          end else begin
            byte_index_next = byte_index + IDX_W'(1);
          end
        end
        PH_LEAD: begin
          if (rx_byte == SYNC_SECOND) begin
            phase_next      = PH_COLLECT;
            byte_index_next = IDX_FIRST_DATA;
          end else if (rx_byte == SYNC_FIRST) begin
            phase_next = PH_LEAD;
          end else begin
            phase_next = PH_HUNT;
          end
        end
        default: begin
          if (rx_byte == SYNC_FIRST) begin
            phase_next = PH_LEAD;
          end else begin
            phase_next = PH_HUNT;
          end
        end
      endcase
    end
  end

  // Outputs: pass frame bytes on to the queue
  always_comb begin
    push            = accept && (phase == PH_COLLECT);
    push_item.data  = rx_byte;
    push_item.index = byte_index;
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      byte_index <= '0;
    end else begin
      phase      <= phase_next;
      byte_index <= byte_index_next;
    end
  end

endmodule

### design/scfd_queue.sv
// Short item queue that decouples the front end from the back end.
module scfd_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  scfd_pkg::frame_item_t push_item,
  output logic                  push_ready,
  output logic                  pop_valid,
  output scfd_pkg::frame_item_t pop_item,
  input  logic                  pop
);
  import scfd_pkg::*;

  frame_item_t       slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push, do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // Store incoming items
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

### design/scfd_back.sv
// Back end: assembles frame fields, checks the sum and holds the result.
module scfd_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  input  scfd_pkg::frame_item_t   item,
  output logic                    item_pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output scfd_pkg::frame_result_t result
);
  import scfd_pkg::*;

  logic [7:0]  fields [FIELD_BYTES];
  logic [15:0] sum_acc;
  logic [7:0]  chk_hi;
  logic        is_last;
  logic        slot_free;
  logic        sum_ok;
  logic        load;
  logic        out_valid_next;
  logic [FIELD_IDX_W-1:0] field_idx;

  assign is_last   = (item.index == IDX_CHK_LO);
  assign slot_free = !out_valid || out_ready;
  assign item_pop  = item_valid && (!is_last || slot_free);
  assign sum_ok    = ({chk_hi, item.data} == sum_acc);
  assign load      = item_pop && is_last && sum_ok;
  assign field_idx = FIELD_IDX_W'(item.index - IDX_FIRST_DATA);

  // Capture payload bytes by position
  always_ff @(posedge clk) begin
    if (item_pop && (item.index <= IDX_LAST_FIELD)) begin
      fields[field_idx] <= item.data;
    end
  end

  // Accumulate the checksum and capture its high byte
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_acc <= '0;
    end else if (item_pop && (item.index < IDX_SUM_END)) begin
      if (item.index == IDX_FIRST_DATA) begin
        sum_acc <= {8'h00, item.data};
      end else begin
        sum_acc <= sum_acc + {8'h00, item.data};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop && (item.index == IDX_CHK_HI)) begin
      chk_hi <= item.data;
    end
  end

  // Output register: load a good frame, drop when taken
  always_comb begin
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.timestamp      <= {fields[0], fields[1]};
      result.pan_speed      <= fields[2];
      result.pan_vel        <= {fields[3], fields[4]};
      result.pan_pos        <= {fields[5], fields[6], fields[7], fields[8]};
      result.tilt_speed     <= fields[9];
      result.tilt_vel       <= {fields[10], fields[11]};
      result.tilt_pos       <= {fields[12], fields[13], fields[14], fields[15]};
      result.roll_speed     <= fields[16];
      result.roll_vel       <= {fields[17], fields[18]};
      result.roll_pos       <= {fields[19], fields[20], fields[21], fields[22]};
      result.direction_bits <= fields[23];
      result.aux_bits       <= fields[24];
    end
  end

endmodule

### design/sync_checksum_frame_deframer.sv
// Top level of the sync checksum frame deframer.
// Takes one received byte per cycle with no gaps of its own: the sync hunter
// decides on each byte combinationally and hands frame bytes through a
// four-item queue to the assembler, which retires one byte per cycle but
// holds a frame's last byte while a result waits. A 36-byte frame starts at
// 0xAA 0x55; bytes 2 to 33 are summed mod 2^16 and compared with bytes 34
// (high) and 35 (low). A good frame is loaded into the output register; a bad
// frame gives no result. Input back-pressure only arises when a result is held
// by out_ready long enough for the queue to fill. No clearing pass.
module sync_checksum_frame_deframer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        timestamp,
  output logic [7:0]         pan_speed,
  output logic signed [15:0] pan_vel,
  output logic signed [31:0] pan_pos,
  output logic [7:0]         tilt_speed,
  output logic signed [15:0] tilt_vel,
  output logic signed [31:0] tilt_pos,
  output logic [7:0]         roll_speed,
  output logic signed [15:0] roll_vel,
  output logic signed [31:0] roll_pos,
  output logic [7:0]         direction_bits,
  output logic [7:0]         aux_bits
);
  import scfd_pkg::*;

  logic          push, push_ready;
  frame_item_t   push_item;
  logic          pop_valid, pop;
  frame_item_t   pop_item;
  frame_result_t result;

  scfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .push       (push),
    .push_item  (push_item),
    .queue_ready(push_ready)
  );

  scfd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .push_ready(push_ready),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop       (pop)
  );

  scfd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .item_valid(pop_valid),
    .item      (pop_item),
    .item_pop  (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  // Break the result out onto its ports
  assign timestamp      = result.timestamp;
  assign pan_speed      = result.pan_speed;
  assign pan_vel        = signed'(result.pan_vel);
  assign pan_pos        = signed'(result.pan_pos);
  assign tilt_speed     = result.tilt_speed;
  assign tilt_vel       = signed'(result.tilt_vel);
  assign tilt_pos       = signed'(result.tilt_pos);
  assign roll_speed     = result.roll_speed;
  assign roll_vel       = signed'(result.roll_vel);
  assign roll_pos       = signed'(result.roll_pos);
  assign direction_bits = result.direction_bits;
  assign aux_bits       = result.aux_bits;

endmodule

### sim/tb.sv
// Self-checking testbench for the sync checksum frame deframer.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import scfd_pkg::*;

  localparam int unsigned MAX_GAP        = 17;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned DRAIN_TAIL     = 10;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned RANDOM_BYTES   = 730;
  localparam int unsigned BODY_LEN       = SUM_END - 2;

  // Frame bytes 2..33, the part covered by the checksum
  typedef logic [7:0] frame_body_t [BODY_LEN];

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         rx_byte;
  logic               out_valid;
  logic               out_ready;
  logic [15:0]        timestamp;
  logic [7:0]         pan_speed;
  logic signed [15:0] pan_vel;
  logic signed [31:0] pan_pos;
  logic [7:0]         tilt_speed;
  logic signed [15:0] tilt_vel;
  logic signed [31:0] tilt_pos;
  logic [7:0]         roll_speed;
  logic signed [15:0] roll_vel;
  logic signed [31:0] roll_pos;
  logic [7:0]         direction_bits;
  logic [7:0]         aux_bits;

  // Deframer tracking state
  phase_t           hunt_phase;
  logic [IDX_W-1:0] next_pos;
  logic [15:0]      running_sum;
  logic [7:0]       frame_copy [FRAME_LEN];

  frame_result_t pending_frames [$];
  int unsigned   frames_predicted = 0;
  int unsigned   bytes_sent = 0;
  int unsigned   mismatch_count = 0;
  int unsigned   idle_cycles = 0;

  bit          tx_steady = 1'b0;
  bit          tx_force_steady = 1'b0;
  bit          rx_steady = 1'b0;
  int unsigned rx_hold_cycles = 0;

  sync_checksum_frame_deframer u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .timestamp      (timestamp),
    .pan_speed      (pan_speed),
    .pan_vel        (pan_vel),
    .pan_pos        (pan_pos),
    .tilt_speed     (tilt_speed),
    .tilt_vel       (tilt_vel),
    .tilt_pos       (tilt_pos),
    .roll_speed     (roll_speed),
    .roll_vel       (roll_vel),
    .roll_pos       (roll_pos),
    .direction_bits (direction_bits),
    .aux_bits       (aux_bits)
  );

  always #5 clk = ~clk;

  // Advance the tracked hunter/assembler by one accepted byte
  task automatic predict_frame_byte(input logic [7:0] b);
    frame_result_t fr;
    if (hunt_phase != PH_COLLECT) begin
      if (hunt_phase == PH_LEAD && b == SYNC_SECOND) begin
        frame_copy[0] = SYNC_FIRST;
        frame_copy[1] = SYNC_SECOND;
        next_pos      = IDX_FIRST_DATA;
        running_sum   = '0;
        hunt_phase    = PH_COLLECT;
      end else if (b == SYNC_FIRST) begin
        hunt_phase = PH_LEAD;
      end else begin
        hunt_phase = PH_HUNT;
      end
    end else begin
      frame_copy[next_pos] = b;
      if (next_pos < IDX_SUM_END) running_sum = running_sum + 16'(b);
      if (next_pos == IDX_CHK_LO) begin
        hunt_phase = PH_HUNT;
        next_pos   = '0;
        if ({frame_copy[IDX_CHK_HI], frame_copy[IDX_CHK_LO]} == running_sum) begin
          fr.timestamp      = {frame_copy[2], frame_copy[3]};
          fr.pan_speed      = frame_copy[4];
          fr.pan_vel        = {frame_copy[5], frame_copy[6]};
          fr.pan_pos        = {frame_copy[7], frame_copy[8], frame_copy[9], frame_copy[10]};
          fr.tilt_speed     = frame_copy[11];
          fr.tilt_vel       = {frame_copy[12], frame_copy[13]};
          fr.tilt_pos       = {frame_copy[14], frame_copy[15], frame_copy[16],
                               frame_copy[17]};
          fr.roll_speed     = frame_copy[18];
          fr.roll_vel       = {frame_copy[19], frame_copy[20]};
          fr.roll_pos       = {frame_copy[21], frame_copy[22], frame_copy[23],
                               frame_copy[24]};
          fr.direction_bits = frame_copy[25];
          fr.aux_bits       = frame_copy[26];
          pending_frames.insert(pending_frames.size(), fr);
          frames_predicted++;
        end
      end else begin
        next_pos = next_pos + IDX_W'(1);
      end
    end
  endtask

  // Offer one byte after a random gap and hold it until accepted
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = (tx_steady || tx_force_steady) ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    predict_frame_byte(b);
    bytes_sent++;
    @(negedge clk);
    if ($urandom_range(0, 63) == 0) tx_steady = !tx_steady;
  endtask

  // Send sync pair, body and checksum; corrupt the checksum on request
  task automatic send_frame(input frame_body_t body, input bit corrupt);
    logic [15:0] sum;
    logic [15:0] chk;
    sum = '0;
    foreach (body[i]) sum = sum + 16'(body[i]);
    chk = corrupt ? (sum ^ 16'($urandom_range(1, 16'hFFFF))) : sum;
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    foreach (body[i]) send_byte(body[i]);
    send_byte(chk[15:8]);
    send_byte(chk[7:0]);
  endtask

  // Pause the sender until every predicted frame is out, then let the pipe settle
  task automatic wait_all_frames();
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(negedge clk);
    repeat (DRAIN_TAIL) @(negedge clk);
  endtask

  // Byte with a bias towards sync codes and field extremes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 11))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return SYNC_FIRST;
      3:       return SYNC_SECOND;
      4:       return 8'h80;
      5:       return 8'h7F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic frame_body_t random_body();
    frame_body_t body;
    foreach (body[i]) body[i] = pick_byte();
    return body;
  endfunction

  function automatic frame_body_t fill_body(input logic [7:0] v);
    frame_body_t body;
    foreach (body[i]) body[i] = v;
    return body;
  endfunction

  // Field extremes: all zero, all ones, signed minimum and maximum
  task automatic test_field_extremes();
    frame_body_t body;
    send_frame(fill_body(8'h00), 1'b0);
    send_frame(fill_body(8'hFF), 1'b0);
    body = fill_body(8'h00);
    // pan at signed minimum, tilt at signed maximum, roll at minus one
    body[3] = 8'h80;
    body[5] = 8'h80;
    body[10] = 8'h7F;
    body[11] = 8'hFF;
    body[12] = 8'h7F;
    for (int i = 13; i <= 22; i++) body[i] = 8'hFF;
    body[10] = 8'h7F;
    for (int i = 25; i < BODY_LEN; i++) body[i] = 8'hA5;
    send_frame(body, 1'b0);
    wait_all_frames();
  endtask

  // Hunting: stray second sync byte, broken lead, repeated lead
  task automatic test_sync_hunting();
    send_byte(SYNC_SECOND);
    send_byte(8'h00);
    send_byte(SYNC_FIRST);
    send_byte(8'h12);
    send_frame(random_body(), 1'b0);
    send_byte(SYNC_FIRST);
    send_frame(random_body(), 1'b0);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_FIRST);
    send_frame(random_body(), 1'b0);
    wait_all_frames();
  endtask

  // Sync codes inside a frame are plain data
  task automatic test_sync_inside_frame();
    frame_body_t body;
    foreach (body[i]) body[i] = (i % 2 == 0) ? SYNC_FIRST : SYNC_SECOND;
    send_frame(body, 1'b0);
    send_frame(fill_body(SYNC_FIRST), 1'b0);
    wait_all_frames();
  endtask

  // Bad checksum drops the frame and the block hunts again
  task automatic test_bad_checksum();
    send_frame(random_body(), 1'b1);
    send_frame(random_body(), 1'b1);
    send_frame(random_body(), 1'b0);
    wait_all_frames();
  endtask

  // Hold the receiver off while frames stream in back to back
  task automatic test_backpressure();
    tx_force_steady = 1'b1;
    rx_hold_cycles  = LONG_HOLD;
    repeat (6) send_frame(random_body(), 1'b0);
    tx_force_steady = 1'b0;
    wait_all_frames();
  endtask

  // Mostly good frames, with noise, bad checksums and cut-short frames
  task automatic test_random_traffic();
    int unsigned start_bytes;
    int unsigned pick;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 7) == 0) send_byte(SYNC_FIRST);
        send_frame(random_body(), 1'b0);
      end else if (pick < 85) begin
        send_frame(random_body(), 1'b1);
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 20)) send_byte(pick_byte());
      end else begin
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        repeat ($urandom_range(0, 30)) send_byte(pick_byte());
      end
    end
    wait_all_frames();
  endtask

  // Receiver: random stall per item, optional long hold-off
  initial begin : receiver
    int unsigned stall;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        stall = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else if (rx_steady) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, MAX_GAP);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
      if ($urandom_range(0, 15) == 0) rx_steady = !rx_steady;
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t %s: expected %h, got %h", $realtime, name, want, got);
    end
  endfunction

  // Compare each delivered frame with the oldest prediction
  always @(posedge clk) begin : frame_checker
    frame_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_frames.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t frame delivered with none predicted", $realtime);
      end else begin
        want = pending_frames.pop_front();
        check_field("timestamp", 32'(want.timestamp), 32'(timestamp));
        check_field("pan_speed", 32'(want.pan_speed), 32'(pan_speed));
        check_field("pan_vel", 32'(want.pan_vel), 32'($unsigned(pan_vel)));
        check_field("pan_pos", want.pan_pos, $unsigned(pan_pos));
        check_field("tilt_speed", 32'(want.tilt_speed), 32'(tilt_speed));
        check_field("tilt_vel", 32'(want.tilt_vel), 32'($unsigned(tilt_vel)));
        check_field("tilt_pos", want.tilt_pos, $unsigned(tilt_pos));
        check_field("roll_speed", 32'(want.roll_speed), 32'(roll_speed));
        check_field("roll_vel", 32'(want.roll_vel), 32'($unsigned(roll_vel)));
        check_field("roll_pos", want.roll_pos, $unsigned(roll_pos));
        check_field("direction_bits", 32'(want.direction_bits), 32'(direction_bits));
        check_field("aux_bits", 32'(want.aux_bits), 32'(aux_bits));
      end
    end
  end

  // Stop the run when nothing moves on either side for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    rx_byte     = 8'h00;
    hunt_phase  = PH_HUNT;
    next_pos    = '0;
    running_sum = '0;
    foreach (frame_copy[i]) frame_copy[i] = 8'h00;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_field_extremes();
    test_sync_hunting();
    test_sync_inside_frame();
    test_bad_checksum();
    test_backpressure();
    test_random_traffic();
    mismatch_count += pending_frames.size();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
